FILE: rtl/box_body_step_with_static_collision_unit_assert.svh
// Assertion macros shared by the box body step block.
`ifndef BOX_BODY_STEP_WITH_STATIC_COLLISION_UNIT_ASSERT_SVH
`define BOX_BODY_STEP_WITH_STATIC_COLLISION_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BSC_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define BSC_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/bsc_pkg.sv
// Types, constants and helpers for the box body step block.
package bsc_pkg;

    localparam int DIVD_W = 48;
    localparam int DEN_W  = 47;

    typedef enum logic [1:0] {
        FUNC_CLEAR = 2'd0,
        FUNC_ADD   = 2'd1,
        FUNC_STEP  = 2'd2
    } func_t;

    typedef enum logic [1:0] {
        REG_GRAV_X    = 2'd0,
        REG_GRAV_Y    = 2'd1,
        REG_TIME_STEP = 2'd2
    } reg_idx_t;

    typedef enum logic [2:0] {
        OP_DEN   = 3'd0,
        OP_GRAV  = 3'd1,
        OP_FORCE = 3'd2,
        OP_VEL   = 3'd3,
        OP_MOVE  = 3'd4
    } op_t;

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_MUL  = 7'b0000010,
        S_ACC  = 7'b0000100,
        S_DIV  = 7'b0001000,
        S_RD   = 7'b0010000,
        S_CMP  = 7'b0100000,
        S_DONE = 7'b1000000
    } state_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

    // Clamp a wide signed value to the signed 32-bit range.
    function automatic logic signed [31:0] sat32(input logic signed [49:0] x);
        logic signed [49:0] hi;
        logic signed [49:0] lo;
        hi = 50'sd2147483647;
        lo = -50'sd2147483648;
        if (x > hi) begin
            sat32 = 32'sh7fffffff;
        end else if (x < lo) begin
            sat32 = 32'sh80000000;
        end else begin
            sat32 = x[31:0];
        end
    endfunction

endpackage

FILE: rtl/bsc_mul.sv
// Shared signed 32 by 32 multiplier with a registered product.
module bsc_mul
    import bsc_pkg::*;
(
    input  logic               aclk,
    input  logic signed [31:0] op_a,
    input  logic signed [31:0] op_b,
    output logic signed [63:0] product
);

    logic signed [63:0] product_reg;

    // Product is registered every cycle; the sequencer reads it in the state after the operands are set.
    always_ff @(posedge aclk) begin
        product_reg <= op_a * op_b;
    end

    assign product = product_reg;

endmodule

FILE: rtl/bsc_div.sv
// Radix-2 restoring divider for the damping step, one quotient bit per cycle.
module bsc_div
    import bsc_pkg::*;
(
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    start,
    input  logic                    neg_in,
    input  logic [DIVD_W-1:0]       dividend,
    input  logic [DEN_W-1:0]        divisor,
    output logic signed [31:0]      quotient,
    output div_status_t             status
);

    logic [5:0]        cnt_reg, cnt_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic              neg_reg, neg_next;
    logic [DIVD_W-1:0] rem_reg, rem_next;
    logic [DIVD_W-1:0] quo_reg, quo_next;
    logic [DIVD_W-1:0] rem_sh;

    // One shift-and-subtract per cycle; the dividend shifts out of quo_reg.
    always_comb begin
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        neg_next  = neg_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        rem_sh    = {rem_reg[DIVD_W-2:0], quo_reg[DIVD_W-1]};
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            quo_next  = dividend;
            neg_next  = neg_in;
        end else if (busy_reg) begin
            if (rem_sh >= {1'b0, divisor}) begin
                rem_next = rem_sh - {1'b0, divisor};
                quo_next = {quo_reg[DIVD_W-2:0], 1'b1};
            end else begin
                rem_next = rem_sh;
                quo_next = {quo_reg[DIVD_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 6'd1;
            if (cnt_reg == 6'(DIVD_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        neg_reg <= neg_next;
        rem_reg <= rem_next;
        quo_reg <= quo_next;
    end

    // Apply the sign; truncation toward zero falls out of magnitude division.
    assign quotient    = neg_reg ? -$signed(quo_reg[31:0]) : $signed(quo_reg[31:0]);
    assign status.busy = busy_reg;
    assign status.done = done_reg;

endmodule

FILE: rtl/box_body_step_with_static_collision_unit.sv
// Top level of the box body stepper with static box collision.
// A step transaction keeps s_ready low until its result is handed on. The shared multiplier
// is used nine times, each use an S_MUL then an S_ACC state. Each of the two damping
// divisions waits in S_DIV for 48 quotient bits and the hand-back of the quotient. The
// collision scan then reads and tests each static box on each axis (S_RD, then S_CMP)
// until a box is hit or the table ends; an axis with a zero move is not scanned. S_DONE
// hands the result to the output register, and only after that can a new step transaction
// be accepted. Clear and add transactions complete in S_IDLE. The block accepts one
// transaction at a time and produces a result only for steps; a finished result waits in
// the output register while the next transaction is accepted.
module box_body_step_with_static_collision_unit
    import bsc_pkg::*;
#(
    parameter int MAX_STATIC_BOXES = 32
)
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_wr_en,
    input  logic [1:0]         cfg_addr,
    input  logic [31:0]        cfg_wr_data,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [1:0]         s_func,
    input  logic signed [31:0] s_pos_x,
    input  logic signed [31:0] s_pos_y,
    input  logic [30:0]        s_size_x,
    input  logic [30:0]        s_size_y,
    input  logic signed [31:0] s_vel_x,
    input  logic signed [31:0] s_vel_y,
    input  logic signed [31:0] s_force_x,
    input  logic signed [31:0] s_force_y,
    input  logic [30:0]        s_inv_mass,
    input  logic [30:0]        s_gravity_weight,
    input  logic [30:0]        s_damping,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [31:0] m_new_pos_x,
    output logic signed [31:0] m_new_pos_y,
    output logic signed [31:0] m_new_vel_x,
    output logic signed [31:0] m_new_vel_y,
    output logic               m_hit_x,
    output logic               m_hit_y,
    output logic               m_table_full
);

    `include "box_body_step_with_static_collision_unit_assert.svh"

    localparam int AW = (MAX_STATIC_BOXES > 1) ? $clog2(MAX_STATIC_BOXES) : 1;
    localparam int CW = $clog2(MAX_STATIC_BOXES + 1);
    localparam logic [CW-1:0] MAX_CNT = CW'(MAX_STATIC_BOXES);

    // Configuration registers.
    logic signed [31:0] grav_x_reg, grav_y_reg;
    logic [30:0]        ts_reg;

    // Sequencer and working registers.
    state_t              state_reg, state_next;
    op_t                 op_reg, op_next;
    logic                ax_reg, ax_next;
    logic [CW-1:0]       count_reg, count_next;
    logic [CW-1:0]       idx_reg, idx_next;
    logic signed [31:0]  pos_reg [2];
    logic signed [31:0]  pos_next [2];
    logic [30:0]         size_reg [2];
    logic signed [31:0]  vel_reg [2];
    logic signed [31:0]  vel_next [2];
    logic signed [31:0]  force_reg [2];
    logic signed [31:0]  d_reg [2];
    logic signed [31:0]  d_next [2];
    logic                hit_reg [2];
    logic                hit_next [2];
    logic [30:0]         im_reg, gw_reg, damp_reg;
    logic [DEN_W-1:0]    den_reg, den_next;
    logic signed [47:0]  t_reg, t_next;
    logic signed [31:0]  acc_reg, acc_next;

    // Output register.
    logic               m_valid_reg, m_valid_next;
    logic signed [31:0] out_px_reg, out_py_reg, out_vx_reg, out_vy_reg;
    logic               out_hx_reg, out_hy_reg, out_full_reg;

    // Static box memory: corner x, corner y, extent x, extent y.
    logic [125:0] box_mem [MAX_STATIC_BOXES];
    logic [125:0] box_rd_reg;

    // Shared arithmetic units.
    logic signed [31:0] mul_a, mul_b;
    logic signed [63:0] product;
    logic signed [47:0] prod_sh;
    logic               div_start;
    logic               div_neg;
    logic [DIVD_W-1:0]  div_dividend;
    logic signed [31:0] div_quo;
    div_status_t        div_stat;
    logic signed [31:0] v1;
    logic [31:0]        v1_mag;

    // Scan helpers.
    logic signed [34:0] lo_x, lo_y, hi_x, hi_y;
    logic signed [34:0] cx, cy, ex, ey;
    logic               overlap;
    logic signed [31:0] snap_pos;
    logic signed [31:0] adv_pos;
    logic               accept;

    bsc_mul u_mul (
        .aclk    (aclk),
        .op_a    (mul_a),
        .op_b    (mul_b),
        .product (product)
    );

    bsc_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .neg_in   (div_neg),
        .dividend (div_dividend),
        .divisor  (den_reg),
        .quotient (div_quo),
        .status   (div_stat)
    );

    assign s_ready = (state_reg == S_IDLE);
    assign accept  = s_valid && s_ready;
    assign prod_sh = product[63:16];

    // Multiplier operand selection by micro-operation.
    always_comb begin
        case (op_reg)
            OP_DEN: begin
                mul_a = $signed({1'b0, ts_reg});
                mul_b = $signed({1'b0, damp_reg});
            end
            OP_GRAV: begin
                mul_a = $signed({1'b0, gw_reg});
                mul_b = ax_reg ? grav_y_reg : grav_x_reg;
            end
            OP_FORCE: begin
                mul_a = $signed({1'b0, im_reg});
                mul_b = force_reg[ax_reg];
            end
            OP_VEL: begin
                mul_a = $signed({1'b0, ts_reg});
                mul_b = acc_reg;
            end
            OP_MOVE: begin
                mul_a = vel_reg[ax_reg];
                mul_b = $signed({1'b0, ts_reg});
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // Integrated velocity and the divider launch.
    assign v1           = sat32(50'(vel_reg[ax_reg]) + 50'(prod_sh));
    assign v1_mag       = v1[31] ? 32'(-v1) : 32'(v1);
    assign div_neg      = v1[31];
    assign div_dividend = {v1_mag, 16'd0};
    assign div_start    = (state_reg == S_ACC) && (op_reg == OP_VEL);

    // Trial box of the current axis move against the registered table entry.
    always_comb begin
        lo_x = 35'(pos_reg[0]);
        lo_y = 35'(pos_reg[1]);
        if (!ax_reg) begin
            lo_x = 35'(pos_reg[0]) + 35'(d_reg[0]);
        end else begin
            lo_y = 35'(pos_reg[1]) + 35'(d_reg[1]);
        end
        hi_x    = lo_x + $signed({4'd0, size_reg[0]});
        hi_y    = lo_y + $signed({4'd0, size_reg[1]});
        cx      = 35'($signed(box_rd_reg[125:94]));
        cy      = 35'($signed(box_rd_reg[93:62]));
        ex      = $signed({4'd0, box_rd_reg[61:31]});
        ey      = $signed({4'd0, box_rd_reg[30:0]});
        overlap = (lo_x < cx + ex) && (cx < hi_x) && (lo_y < cy + ey) && (cy < hi_y);
        if (d_reg[ax_reg] < 0) begin
            snap_pos = sat32(50'(ax_reg ? cy + ey : cx + ex));
        end else begin
            snap_pos = sat32(50'(ax_reg ? cy : cx) - 50'($signed({1'b0, size_reg[ax_reg]})));
        end
        adv_pos = sat32(50'(pos_reg[ax_reg]) + 50'(d_reg[ax_reg]));
    end

    // Sequencer.
    always_comb begin
        state_next   = state_reg;
        op_next      = op_reg;
        ax_next      = ax_reg;
        count_next   = count_reg;
        idx_next     = idx_reg;
        pos_next     = pos_reg;
        vel_next     = vel_reg;
        d_next       = d_reg;
        hit_next     = hit_reg;
        den_next     = den_reg;
        t_next       = t_reg;
        acc_next     = acc_reg;
        m_valid_next = m_valid_reg;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    case (s_func)
                        FUNC_CLEAR: count_next = '0;
                        FUNC_ADD: begin
                            if (count_reg < MAX_CNT) begin
                                count_next = count_reg + 1'b1;
                            end
                        end
                        FUNC_STEP: begin
                            pos_next[0] = s_pos_x;
                            pos_next[1] = s_pos_y;
                            vel_next[0] = s_vel_x;
                            vel_next[1] = s_vel_y;
                            hit_next[0] = 1'b0;
                            hit_next[1] = 1'b0;
                            op_next     = OP_DEN;
                            ax_next     = 1'b0;
                            state_next  = S_MUL;
                        end
                        default: state_next = S_IDLE;
                    endcase
                end
            end
            S_MUL: state_next = S_ACC;
            S_ACC: begin
                state_next = S_MUL;
                case (op_reg)
                    OP_DEN: begin
                        den_next = DEN_W'(product[63:16]) + DEN_W'(65536);
                        op_next  = OP_GRAV;
                    end
                    OP_GRAV: begin
                        t_next  = prod_sh;
                        op_next = OP_FORCE;
                    end
                    OP_FORCE: begin
                        acc_next = sat32(50'(t_reg) + 50'(prod_sh));
                        op_next  = OP_VEL;
                    end
                    OP_VEL: state_next = S_DIV;
                    OP_MOVE: begin
                        d_next[ax_reg] = sat32(50'(prod_sh));
                        if (!ax_reg) begin
                            ax_next = 1'b1;
                            op_next = OP_GRAV;
                        end else begin
                            ax_next    = 1'b0;
                            idx_next   = '0;
                            state_next = S_RD;
                        end
                    end
                    default: state_next = S_IDLE;
                endcase
            end
            S_DIV: begin
                if (div_stat.done) begin
                    vel_next[ax_reg] = div_quo;
                    op_next          = OP_MOVE;
                    state_next       = S_MUL;
                end
            end
            S_RD: begin
                if (d_reg[ax_reg] == 0 || idx_reg >= count_reg) begin
                    if (d_reg[ax_reg] != 0) begin
                        pos_next[ax_reg] = adv_pos;
                    end
                    idx_next = '0;
                    if (!ax_reg) begin
                        ax_next = 1'b1;
                    end else begin
                        state_next = S_DONE;
                    end
                end else begin
                    state_next = S_CMP;
                end
            end
            S_CMP: begin
                if (overlap) begin
                    pos_next[ax_reg] = snap_pos;
                    vel_next[ax_reg] = '0;
                    hit_next[ax_reg] = 1'b1;
                    idx_next         = '0;
                    if (!ax_reg) begin
                        ax_next    = 1'b1;
                        state_next = S_RD;
                    end else begin
                        state_next = S_DONE;
                    end
                end else begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = S_RD;
                end
            end
            S_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
            grav_x_reg  <= '0;
            grav_y_reg  <= -32'sd3276800;
            ts_reg      <= 31'd1092;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
            if (cfg_wr_en) begin
                case (cfg_addr)
                    REG_GRAV_X:    grav_x_reg <= cfg_wr_data;
                    REG_GRAV_Y:    grav_y_reg <= cfg_wr_data;
                    REG_TIME_STEP: ts_reg     <= cfg_wr_data[30:0];
                    default:       ts_reg     <= ts_reg;
                endcase
            end
        end
    end

    // Working and payload registers.
    always_ff @(posedge aclk) begin
        op_reg   <= op_next;
        ax_reg   <= ax_next;
        idx_reg  <= idx_next;
        pos_reg  <= pos_next;
        vel_reg  <= vel_next;
        d_reg    <= d_next;
        hit_reg  <= hit_next;
        den_reg  <= den_next;
        t_reg    <= t_next;
        acc_reg  <= acc_next;
        if (accept && s_func == FUNC_STEP) begin
            size_reg[0]  <= s_size_x;
            size_reg[1]  <= s_size_y;
            force_reg[0] <= s_force_x;
            force_reg[1] <= s_force_y;
            im_reg       <= s_inv_mass;
            gw_reg       <= s_gravity_weight;
            damp_reg     <= s_damping;
        end
        if (state_reg == S_DONE && (!m_valid_reg || m_ready)) begin
            out_px_reg   <= pos_reg[0];
            out_py_reg   <= pos_reg[1];
            out_vx_reg   <= vel_reg[0];
            out_vy_reg   <= vel_reg[1];
            out_hx_reg   <= hit_reg[0];
            out_hy_reg   <= hit_reg[1];
            out_full_reg <= (count_reg >= MAX_CNT);
        end
    end

    // Box memory: written by add transactions, read one entry per scan step.
    always_ff @(posedge aclk) begin
        if (accept && s_func == FUNC_ADD && count_reg < MAX_CNT) begin
            box_mem[count_reg[AW-1:0]] <= {s_pos_x, s_pos_y, s_size_x, s_size_y};
        end
        if (state_reg == S_RD) begin
            box_rd_reg <= box_mem[idx_reg[AW-1:0]];
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_new_pos_x  = out_px_reg;
    assign m_new_pos_y  = out_py_reg;
    assign m_new_vel_x  = out_vx_reg;
    assign m_new_vel_y  = out_vy_reg;
    assign m_hit_x      = out_hx_reg;
    assign m_hit_y      = out_hy_reg;
    assign m_table_full = out_full_reg;

    // The box count never exceeds the table depth.
    `BSC_ASSERT_NOW(a_count_bound, aclk, aresetn, 1'b1, count_reg <= MAX_CNT, "box count over depth")
    // The divider runs only while the sequencer waits for it.
    `BSC_ASSERT_NOW(a_div_owner, aclk, aresetn, div_stat.busy, state_reg == S_DIV, "divider busy outside wait")
    // An add to a table with room grows the count by one.
    `BSC_ASSERT_NEXT(a_add_grows, aclk, aresetn, accept && s_func == FUNC_ADD && count_reg < MAX_CNT, count_reg == $past(count_reg) + 1'b1, "add did not grow count")

endmodule
